/* rtl/ikht_pkg.sv */
// Package for the integer-key hash table: geometry constants, codes, types
// and the key mixing function. No dependencies.
package ikht_pkg;

  localparam int unsigned BUCKETS     = 16;
  localparam int unsigned WAYS        = 4;
  localparam int unsigned VALUE_WIDTH = 32;

  localparam int unsigned SLOTS  = BUCKETS * WAYS;
  localparam int unsigned BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned TOT_W  = 7;

  typedef enum logic [1:0] {
    FUNC_GET    = 2'd0,
    FUNC_PUT    = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [KEY_W-1:0]       hash_t;

  // Two rounds of arithmetic-shift xors; a bijection on 32 bits.
  function automatic hash_t mix_key(input hash_t k);
    hash_t h1;
    h1 = k ^ hash_t'($signed(k) >>> 20) ^ hash_t'($signed(k) >>> 12);
    return h1 ^ hash_t'($signed(h1) >>> 7) ^ hash_t'($signed(h1) >>> 4);
  endfunction

endpackage

/* rtl/ikht_if.sv */
// Request and response channel interfaces for the hash table.
// Depends on ikht_pkg.
interface ikht_req_if;
  logic                      valid;
  logic                      ready;
  ikht_pkg::func_e           func;
  logic signed [31:0]        key;
  logic [31:0]               data_in;

  modport source (output valid, func, key, data_in, input ready);
  modport sink   (input valid, func, key, data_in, output ready);
endinterface

interface ikht_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic [31:0]               data_out;
  logic                      status;
  logic [6:0]                entry_total;

  modport source (output valid, found, data_out, status, entry_total, input ready);
  modport sink   (input valid, found, data_out, status, entry_total, output ready);
endinterface

/* rtl/int_key_hash_table_unit.sv */
// Integer-key hash table, BUCKETS x WAYS entries, one bucket row per memory word.
// The row is read on the accepting edge; modify/write and response load follow in the
//   execute state once the response register is free. A new request is taken only
//   after the last leaves the execute state, as the bucket row in the hash and value
//   memories gets a single read-modify-write; a held response stalls the next write.
// Reset clears valid bits, entry count, FSM and response valid at once; the memories
//   themselves are not cleared (entries are only seen through their valid bits).
module int_key_hash_table_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  ikht_req_if.sink   req_i,
  ikht_rsp_if.source rsp_o
);

  // Bucket row memories: one word per bucket, all ways side by side.
  ikht_pkg::hash_t  [ikht_pkg::WAYS-1:0] hash_mem  [ikht_pkg::BUCKETS];
  ikht_pkg::value_t [ikht_pkg::WAYS-1:0] value_mem [ikht_pkg::BUCKETS];

  // Valid bits live in flops so reset and clear empty the whole table together.
  logic [ikht_pkg::BUCKETS-1:0][ikht_pkg::WAYS-1:0] valid_q, valid_d;
  logic [ikht_pkg::CNT_W-1:0] cnt_q, cnt_d;

  ikht_pkg::state_e state_q, state_d;

  // Request beat captured for the execute cycle.
  ikht_pkg::func_e              func_q;
  ikht_pkg::hash_t              hash_q;
  ikht_pkg::value_t             din_q;
  logic [ikht_pkg::BKT_W-1:0]   bkt_q;

  // Registered row read data.
  ikht_pkg::hash_t  [ikht_pkg::WAYS-1:0] rd_hash_q;
  ikht_pkg::value_t [ikht_pkg::WAYS-1:0] rd_val_q;

  // Response register.
  logic                         rsp_valid_q, rsp_valid_d;
  logic                         found_q;
  logic [ikht_pkg::DATA_W-1:0]  data_out_q;
  logic                         status_q;
  logic [ikht_pkg::TOT_W-1:0]   total_q;

  logic                         req_fire;
  logic                         rsp_free;
  logic                         do_exec;
  ikht_pkg::hash_t              req_hash;

  // Execute-cycle results.
  logic                         hit_any, free_any;
  logic [ikht_pkg::WAY_W-1:0]   hit_way, free_way;
  logic                         wr_en;
  ikht_pkg::hash_t  [ikht_pkg::WAYS-1:0] wr_hash;
  ikht_pkg::value_t [ikht_pkg::WAYS-1:0] wr_val;
  logic                         ex_found, ex_status;
  logic [ikht_pkg::DATA_W-1:0]  ex_data;

  assign req_hash = ikht_pkg::mix_key(req_i.key);
  assign req_fire = req_i.valid && req_i.ready;
  assign rsp_free = !rsp_valid_q || rsp_o.ready;
  assign do_exec  = (state_q == ikht_pkg::ST_EXEC) && rsp_free;

  // ---------------------------------------------------------------- FSM
  always_comb begin
    state_d = state_q;
    case (state_q)
      ikht_pkg::ST_IDLE: if (req_fire) state_d = ikht_pkg::ST_EXEC;
      ikht_pkg::ST_EXEC: if (rsp_free) state_d = ikht_pkg::ST_IDLE;
      default:           state_d = ikht_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready = 1'b0;
    case (state_q)
      ikht_pkg::ST_IDLE: req_i.ready = 1'b1;
      ikht_pkg::ST_EXEC: req_i.ready = 1'b0;
      default:           req_i.ready = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------- row read
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      rd_hash_q <= hash_mem[req_hash[ikht_pkg::BKT_W-1:0]];
      rd_val_q  <= value_mem[req_hash[ikht_pkg::BKT_W-1:0]];
      func_q    <= req_i.func;
      hash_q    <= req_hash;
      bkt_q     <= req_hash[ikht_pkg::BKT_W-1:0];
      din_q     <= ikht_pkg::VALUE_WIDTH'(req_i.data_in);
    end
  end

  // ---------------------------------------------------------------- way match
  // Lowest-numbered matching way and lowest-numbered free way.
  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int w = ikht_pkg::WAYS - 1; w >= 0; w--) begin
      if (valid_q[bkt_q][w]) begin
        if (rd_hash_q[w] == hash_q) begin
          hit_any = 1'b1;
          hit_way = ikht_pkg::WAY_W'(w);
        end
      end else begin
        free_any = 1'b1;
        free_way = ikht_pkg::WAY_W'(w);
      end
    end
  end

  // ---------------------------------------------------------------- modify
  always_comb begin
    wr_en     = 1'b0;
    wr_hash   = rd_hash_q;
    wr_val    = rd_val_q;
    valid_d   = valid_q;
    cnt_d     = cnt_q;
    ex_found  = 1'b0;
    ex_status = 1'b0;
    ex_data   = '0;
    if (do_exec) begin
      if (func_q == ikht_pkg::FUNC_CLEAR) begin
        valid_d = '0;
        cnt_d   = '0;
      end else if (hit_any) begin
        ex_found = 1'b1;
        ex_data  = ikht_pkg::DATA_W'(rd_val_q[hit_way]);
        if (func_q == ikht_pkg::FUNC_PUT) begin
          wr_en           = 1'b1;
          wr_val[hit_way] = din_q;
        end else if (func_q == ikht_pkg::FUNC_REMOVE) begin
          valid_d[bkt_q][hit_way] = 1'b0;
          if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
        end
      end else if (func_q == ikht_pkg::FUNC_PUT) begin
        if (free_any) begin
          wr_en                    = 1'b1;
          wr_hash[free_way]        = hash_q;
          wr_val[free_way]         = din_q;
          valid_d[bkt_q][free_way] = 1'b1;
          cnt_d                    = cnt_q + 1'b1;
        end else begin
          ex_status = 1'b1;  // bucket full, nothing stored
        end
      end
    end
  end

  // Write-back; the next row read happens on a later edge than this write, so no bypass is needed.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hash_mem[bkt_q]  <= wr_hash;
      value_mem[bkt_q] <= wr_val;
    end
  end

  // ---------------------------------------------------------------- response
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_o.ready) rsp_valid_d = 1'b0;
    if (do_exec)     rsp_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (do_exec) begin
      found_q    <= ex_found;
      data_out_q <= ex_data;
      status_q   <= ex_status;
      total_q    <= ikht_pkg::TOT_W'(cnt_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ikht_pkg::ST_IDLE;
      valid_q     <= '0;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.found       = found_q;
  assign rsp_o.data_out    = data_out_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.entry_total = total_q;

  // ---------------------------------------------------------------- checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ikht_pkg::CNT_W'(ikht_pkg::SLOTS))
    else $error("entry count above table size");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> state_q == ikht_pkg::ST_EXEC)
    else $error("accepted beat did not enter execute");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_exec && func_q == ikht_pkg::FUNC_CLEAR) |=> (cnt_q == '0 && valid_q == '0))
    else $error("clear left entries behind");

  a_full_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && status_q) |-> !found_q)
    else $error("full-bucket status with a hit");

  a_exec_loads_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_exec |=> rsp_valid_q)
    else $error("executed beat produced no response");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for int_key_hash_table_unit: a shadow table predicts each beat.
// Depends on rtl/ikht_pkg.sv, rtl/ikht_if.sv and rtl/int_key_hash_table_unit.sv.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Generous ceiling for ~540 requests under heavy stalls.
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned POOL_SIZE   = 24;
  localparam int unsigned MAX_SHOWN   = 10;
  localparam int unsigned SENDER      = 0;
  localparam int unsigned RECEIVER    = 1;

  typedef struct packed {
    ikht_pkg::func_e func;
    logic [31:0]     key;
    logic [31:0]     data;
  } table_req_t;

  typedef struct packed {
    logic       found;
    logic [31:0] data;
    logic       status;
    logic [6:0] total;
  } table_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ikht_req_if req ();
  ikht_rsp_if rsp ();

  int_key_hash_table_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always #5 clk_i = ~clk_i;

  // Requests waiting to be driven, and responses owed by the block, oldest first.
  table_req_t req_backlog[$];
  table_rsp_t rsp_due[$];

  // Shadow copy of the table contents.
  logic [31:0] shadow_hash  [ikht_pkg::SLOTS];
  logic [31:0] shadow_value [ikht_pkg::SLOTS];
  bit          shadow_valid [ikht_pkg::SLOTS];
  int unsigned shadow_count;

  int unsigned mismatches;
  int unsigned cycles;

  // Idle percentage per side.
  int unsigned idle_pct [2];

  // Arithmetic right shift done by hand on a sign-extended copy.
  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    logic [63:0] ext;
    ext = {{32{x[31]}}, x};
    ext = ext >> n;
    return ext[31:0];
  endfunction

  function automatic logic [31:0] mixed_hash(input logic [31:0] k);
    logic [31:0] h;
    h = k ^ asr(k, 20) ^ asr(k, 12);
    return h ^ asr(h, 7) ^ asr(h, 4);
  endfunction

  function automatic logic [31:0] key_in_bucket(input int unsigned bkt);
    logic [31:0] k;
    do
      k = $urandom();
    while ((mixed_hash(k) & (ikht_pkg::BUCKETS - 1)) != bkt);
    return k;
  endfunction

  // Applies one accepted request to the shadow table and queues the response it owes.
  function automatic void shadow_apply(input table_req_t r);
    logic [31:0] h;
    int unsigned base;
    int          hit;
    int          free_way;
    table_rsp_t  e;
    h        = mixed_hash(r.key);
    base     = (h & (ikht_pkg::BUCKETS - 1)) * ikht_pkg::WAYS;
    hit      = -1;
    free_way = -1;
    e        = '0;
    for (int w = 0; w < ikht_pkg::WAYS; w++) begin
      if (shadow_valid[base + w]) begin
        if (hit < 0 && shadow_hash[base + w] == h) hit = w;
      end else if (free_way < 0) begin
        free_way = w;
      end
    end
    if (r.func == ikht_pkg::FUNC_CLEAR) begin
      foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
      shadow_count = 0;
    end else if (hit >= 0) begin
      e.found = 1'b1;
      e.data  = shadow_value[base + hit];
      if (r.func == ikht_pkg::FUNC_PUT) begin
        shadow_value[base + hit] = r.data;
      end else if (r.func == ikht_pkg::FUNC_REMOVE) begin
        shadow_valid[base + hit] = 1'b0;
        if (shadow_count > 0) shadow_count--;
      end
    end else if (r.func == ikht_pkg::FUNC_PUT) begin
      if (free_way >= 0) begin
        shadow_valid[base + free_way] = 1'b1;
        shadow_hash[base + free_way]  = h;
        shadow_value[base + free_way] = r.data;
        shadow_count++;
      end else begin
        e.status = 1'b1;
      end
    end
    e.total = shadow_count[6:0];
    rsp_due.push_back(e);
  endfunction

  // Random idling at the phase's percentage.
  function bit idle_now(input int unsigned side);
    return $urandom_range(0, 99) < idle_pct[side];
  endfunction

  function automatic void queue_req(input ikht_pkg::func_e f, input logic [31:0] k,
                                    input logic [31:0] d);
    table_req_t r;
    r.func = f;
    r.key  = k;
    r.data = d;
    req_backlog.push_back(r);
  endfunction

  // Mixed traffic over a small key pool so hits, misses and full buckets all occur.
  task automatic queue_random(input int unsigned n);
    logic [31:0] pool [POOL_SIZE];
    logic [31:0] k;
    logic [31:0] d;
    int unsigned pick;
    foreach (pool[i]) pool[i] = $urandom();
    repeat (n) begin
      k = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom();
      case ($urandom_range(0, 9))
        0:       d = 32'h0000_0000;
        1:       d = 32'hFFFF_FFFF;
        default: d = $urandom();
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 2)       queue_req(ikht_pkg::FUNC_CLEAR, k, d);
      else if (pick < 42) queue_req(ikht_pkg::FUNC_PUT, k, d);
      else if (pick < 72) queue_req(ikht_pkg::FUNC_GET, k, d);
      else                queue_req(ikht_pkg::FUNC_REMOVE, k, d);
    end
  endtask

  // Request driver: the shadow table is updated at the edge where a beat is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    table_req_t nxt;
    if (!rst_ni) begin
      req.valid   <= 1'b0;
      req.func    <= ikht_pkg::FUNC_GET;
      req.key     <= '0;
      req.data_in <= '0;
    end else begin
      if (req.valid && req.ready) begin
        nxt.func = req.func;
        nxt.key  = req.key;
        nxt.data = req.data_in;
        shadow_apply(nxt);
      end
      if (!req.valid || req.ready) begin
        if (req_backlog.size() > 0 && !idle_now(SENDER)) begin
          nxt = req_backlog.pop_front();
          req.valid   <= 1'b1;
          req.func    <= nxt.func;
          req.key     <= nxt.key;
          req.data_in <= nxt.data;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: each beat taken is checked against the oldest owed response.
  always @(posedge clk_i or negedge rst_ni) begin
    table_rsp_t e;
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (rsp_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("%0t: response beat with nothing owed", $realtime);
        end else begin
          e = rsp_due.pop_front();
          if (rsp.found !== e.found || rsp.data_out !== e.data ||
              rsp.status !== e.status || rsp.entry_total !== e.total) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("%0t: mismatch found %0b/%0b data %h/%h status %0b/%0b total %0d/%0d",
                       $realtime, e.found, rsp.found, e.data, rsp.data_out,
                       e.status, rsp.status, e.total, rsp.entry_total);
          end
        end
      end
      rsp.ready <= !idle_now(RECEIVER);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [31:0] same_bkt [4];
    int unsigned bkt;

    // Known levels on every block input from time zero.
    rst_ni      = 1'b0;
    req.valid   = 1'b0;
    req.func    = ikht_pkg::FUNC_GET;
    req.key     = '0;
    req.data_in = '0;
    rsp.ready   = 1'b0;
    mismatches  = 0;
    cycles      = 0;
    idle_pct    = '{0, 0};
    foreach (shadow_valid[i]) begin
      shadow_valid[i] = 1'b0;
      shadow_hash[i]  = '0;
      shadow_value[i] = '0;
    end
    shadow_count = 0;

    // Directed part: empty-table misses, extreme keys and values, overwrite, remove.
    queue_req(ikht_pkg::FUNC_GET,    32'h0000_0000, 32'hFFFF_FFFF);
    queue_req(ikht_pkg::FUNC_REMOVE, 32'h7FFF_FFFF, 32'h0000_0000);
    queue_req(ikht_pkg::FUNC_PUT,    32'h8000_0000, 32'hFFFF_FFFF);
    queue_req(ikht_pkg::FUNC_PUT,    32'h7FFF_FFFF, 32'h0000_0000);
    queue_req(ikht_pkg::FUNC_PUT,    32'hFFFF_FFFF, 32'hA5A5_A5A5);
    queue_req(ikht_pkg::FUNC_PUT,    32'h0000_0000, 32'h5A5A_5A5A);
    queue_req(ikht_pkg::FUNC_GET,    32'h8000_0000, 32'h0000_0000);
    queue_req(ikht_pkg::FUNC_PUT,    32'h8000_0000, 32'h1234_5678);
    queue_req(ikht_pkg::FUNC_REMOVE, 32'h7FFF_FFFF, 32'hDEAD_BEEF);
    queue_req(ikht_pkg::FUNC_GET,    32'h7FFF_FFFF, 32'h0000_0000);

    // Fill the bucket that key 0 lives in, overflow it, then reuse the freed way.
    bkt = mixed_hash(32'h0) & (ikht_pkg::BUCKETS - 1);
    foreach (same_bkt[i]) same_bkt[i] = key_in_bucket(bkt);
    for (int i = 0; i < 4; i++) queue_req(ikht_pkg::FUNC_PUT, same_bkt[i], $urandom());
    queue_req(ikht_pkg::FUNC_REMOVE, same_bkt[1], 32'h0);
    queue_req(ikht_pkg::FUNC_PUT,    same_bkt[3], 32'hFFFF_FFFF);
    queue_req(ikht_pkg::FUNC_GET,    same_bkt[3], 32'h0);
    queue_req(ikht_pkg::FUNC_GET,    32'h0000_0000, 32'h0);

    // Clear, then confirm the table starts over.
    queue_req(ikht_pkg::FUNC_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_req(ikht_pkg::FUNC_GET,    32'h8000_0000, 32'h0);
    queue_req(ikht_pkg::FUNC_PUT,    same_bkt[0], 32'h0000_0001);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Idle phases: none, sender 76%, receiver 76%, both 37%.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       idle_pct = '{0, 0};
        1:       idle_pct = '{76, 0};
        2:       idle_pct = '{0, 76};
        default: idle_pct = '{37, 37};
      endcase
      if (ph == 0) begin
        // Drive the table to all 64 entries; the fifth put per bucket overflows.
        queue_req(ikht_pkg::FUNC_CLEAR, $urandom(), $urandom());
        for (int b = 0; b < ikht_pkg::BUCKETS; b++)
          for (int w = 0; w <= ikht_pkg::WAYS; w++)
            queue_req(ikht_pkg::FUNC_PUT, key_in_bucket(b), $urandom());
      end
      queue_random(110);
      while (req_backlog.size() > 0 || req.valid || rsp_due.size() > 0)
        @(posedge clk_i);
    end

    // A beat popped on the last edge shows up as valid a step later; drain it too.
    repeat (2) @(posedge clk_i);
    while (req_backlog.size() > 0 || req.valid || rsp_due.size() > 0)
      @(posedge clk_i);

    repeat (10) @(posedge clk_i);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
